@@ rtl/core/ostt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostt_pkg
// Shared types and codes for the one-shot timer table.
// ----------------------------------------------------------------------------
package ostt_pkg;

   localparam int DeadlineBits = 64;
   localparam int MaxResults   = 16;
   localparam int RetireBits   = 5;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_POLL = 1'b1;

   localparam logic [1:0] KIND_ADDED = 2'd0;
   localparam logic [1:0] KIND_FULL  = 2'd1;
   localparam logic [1:0] KIND_FIRED = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [63:0] deadline;
      logic [7:0]  handler_tag;
      logic [63:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] slot;
      logic [7:0] fired_tag;
      logic [4:0] active_count;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/core/ostt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ostt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ostt_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/one_shot_timer_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_table_unit
// Table of one-shot timers: add to lowest free slot, poll retires due timers.
// ----------------------------------------------------------------------------
//  channel  ports                          direction  payload
//  req      req_valid req_ready req_data   in         ostt_pkg::req_type
//  rsp      rsp_valid rsp_ready rsp_data   out        ostt_pkg::rsp_type
//
//  add: visits slots in order up to the first free one, then finishes;
//  a full table has every slot visited
//  poll: visits slots in order up to the last or the retire cap; an
//  occupied slot takes a registered table read, then the shared 64-bit deadline compare
//  reset clears all valid bits at once; no clearing pass
//  a fired result waiting on rsp_ready holds the scan at the next due slot
// ----------------------------------------------------------------------------
module one_shot_timer_table_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ostt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ostt_pkg::rsp_type rsp_data
);

   localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int RamW = ostt_pkg::DeadlineBits + TAG_BITS;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

   ostt_pkg::state_type state_ff, state_in;
   logic [IdxW-1:0]          idx_ff, idx_in;
   logic [QUEUE_DEPTH-1:0]   valid_ff, valid_in;
   logic [CntW-1:0]          count_ff, count_in;
   logic [ostt_pkg::RetireBits-1:0] ret_ff, ret_in;
   ostt_pkg::req_type        req_ff, req_in;
   ostt_pkg::rsp_type        pend_ff, pend_in;
   logic                     pend_vld_ff, pend_vld_in;
   ostt_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     ram_wr_en;
   logic [RamW-1:0]          ram_rd_data;
   logic [ostt_pkg::DeadlineBits-1:0] rd_deadline;
   logic [TAG_BITS-1:0]      rd_tag;
   logic                     due;
   logic                     can_push;
   logic                     last_slot;
   logic                     cur_valid;
   logic                     ret_cap;

   ostt_ram #(
      .WIDTH (RamW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data ({req_ff.deadline, TAG_BITS'(req_ff.handler_tag)}),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_deadline = ram_rd_data[RamW-1 -: ostt_pkg::DeadlineBits];
   assign rd_tag      = ram_rd_data[TAG_BITS-1:0];
   // shared compare unit
   assign due         = req_ff.now_time >= rd_deadline;
   assign can_push    = !rsp_valid_ff || rsp_ready;
   assign last_slot   = idx_ff == LastIdx;
   assign cur_valid   = valid_ff[idx_ff];
   assign ret_cap     = ret_ff == ostt_pkg::RetireBits'(ostt_pkg::MaxResults);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ostt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ostt_pkg::ST_SCAN;
            end
         end
         ostt_pkg::ST_SCAN: begin
            if (req_ff.mode == ostt_pkg::MODE_ADD) begin
               if (!cur_valid || last_slot) begin
                  state_in = ostt_pkg::ST_FINISH;
               end
            end else if (ret_cap) begin
               state_in = ostt_pkg::ST_FINISH;
            end else if (cur_valid) begin
               state_in = ostt_pkg::ST_CHECK;
            end else if (last_slot) begin
               state_in = ostt_pkg::ST_FINISH;
            end
         end
         ostt_pkg::ST_CHECK: begin
            if (!(due && pend_vld_ff && !can_push)) begin
               state_in = last_slot ? ostt_pkg::ST_FINISH : ostt_pkg::ST_SCAN;
            end
         end
         ostt_pkg::ST_FINISH: begin
            if (can_push) begin
               state_in = ostt_pkg::ST_IDLE;
            end
         end
         default: state_in = ostt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      ret_in       = ret_ff;
      req_in       = req_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      unique case (state_ff)
         ostt_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               idx_in      = '0;
               ret_in      = '0;
               pend_vld_in = 1'b0;
            end
         end
         ostt_pkg::ST_SCAN: begin
            if (req_ff.mode == ostt_pkg::MODE_ADD) begin
               if (!cur_valid) begin
                  ram_wr_en              = 1'b1;
                  valid_in[idx_ff]       = 1'b1;
                  count_in               = count_ff + CntW'(1);
                  pend_in.kind           = ostt_pkg::KIND_ADDED;
                  pend_in.slot           = 4'(idx_ff);
                  pend_in.fired_tag      = '0;
                  pend_in.active_count   = 5'(count_ff + CntW'(1));
                  pend_in.last           = 1'b1;
                  pend_vld_in            = 1'b1;
               end else if (last_slot) begin
                  pend_in.kind           = ostt_pkg::KIND_FULL;
                  pend_in.slot           = '0;
                  pend_in.fired_tag      = '0;
                  pend_in.active_count   = 5'(count_ff);
                  pend_in.last           = 1'b1;
                  pend_vld_in            = 1'b1;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
               end
            end else if (!ret_cap && !cur_valid && !last_slot) begin
               idx_in = idx_ff + IdxW'(1);
            end
         end
         ostt_pkg::ST_CHECK: begin
            if (due) begin
               if (!(pend_vld_ff && !can_push)) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_ff;
                  end
                  valid_in[idx_ff]     = 1'b0;
                  count_in             = count_ff - CntW'(1);
                  ret_in               = ret_ff + ostt_pkg::RetireBits'(1);
                  pend_in.kind         = ostt_pkg::KIND_FIRED;
                  pend_in.slot         = 4'(idx_ff);
                  pend_in.fired_tag    = 8'(rd_tag);
                  pend_in.active_count = 5'(count_ff - CntW'(1));
                  pend_in.last         = 1'b0;
                  pend_vld_in          = 1'b1;
                  if (!last_slot) begin
                     idx_in = idx_ff + IdxW'(1);
                  end
               end
            end else if (!last_slot) begin
               idx_in = idx_ff + IdxW'(1);
            end
         end
         ostt_pkg::ST_FINISH: begin
            if (can_push) begin
               rsp_valid_in = 1'b1;
               if (pend_vld_ff) begin
                  rsp_data_in      = pend_ff;
                  rsp_data_in.last = 1'b1;
               end else begin
                  rsp_data_in.kind         = ostt_pkg::KIND_NONE;
                  rsp_data_in.slot         = '0;
                  rsp_data_in.fired_tag    = '0;
                  rsp_data_in.active_count = 5'(count_ff);
                  rsp_data_in.last         = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ostt_pkg::ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ret_ff      <= ret_in;
      req_ff      <= req_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = state_ff == ostt_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(valid_ff))
      else $error("active count out of step with valid bits");

   a_check_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ostt_pkg::ST_CHECK |->
         ($past(state_ff) == ostt_pkg::ST_SCAN || $past(state_ff) == ostt_pkg::ST_CHECK))
      else $error("compare phase entered without a table read");

   a_finish_gives_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ostt_pkg::ST_FINISH && can_push) |=> (rsp_valid && rsp_data.last))
      else $error("item closed without a final transfer");
`endif

endmodule
